@@ hdl/hst_pkg.sv @@
// Shared types and constants of the heard station table.
`default_nettype none

package hst_pkg;

    localparam int ADDR_W   = 56;
    localparam int TYPE_W   = 8;
    localparam int PORT_W   = 4;
    localparam int PLEN_W   = 4;
    localparam int COUNT_W  = 16;
    localparam int SLOT_W   = 5;
    localparam int STATUS_W = 3;
    localparam int NOW_W    = 32;
    localparam int SIZE_W   = 6;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 32;

    localparam int TABLE_DEPTH_DEF = 32;
    localparam int MAX_PATH_DEF    = 8;
    localparam int TIME_BITS_DEF   = 32;

    localparam logic [TYPE_W-1:0] BLANK_TYPE = 8'h20;

    // Address bits that take part in a match: the callsign bytes and the SSID.
    localparam logic [ADDR_W-1:0] MATCH_MASK = 56'hFF_FFFF_FFFF_FF1E;

    // Register select, taken from bit 2 of the byte address.
    localparam logic REG_TABLE_SIZE  = 1'b0;
    localparam logic REG_TYPE_IN_KEY = 1'b1;

    typedef enum logic [0:0] {
        OP_UPDATE = 1'b0,
        OP_LOOKUP = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_REFRESHED = 3'd0,
        STAT_INSERTED  = 3'd1,
        STAT_REPLACED  = 3'd2,
        STAT_DISABLED  = 3'd3,
        STAT_HIT       = 3'd4,
        STAT_MISS      = 3'd5
    } status_t;

endpackage

`default_nettype wire

@@ hdl/heard_station_table.sv @@
// Top level of the heard station table: sequencer, registers and ports.
//
// The block keeps up to table_size stations heard (at most TABLE_DEPTH) in one
// RAM with one record per entry. An item on a non-empty table walks the used
// entries in order, one RAM read per cycle, comparing each record against the
// address with one shared compare unit and tracking the oldest time for
// replacement, up to the first match or the last used entry,
// and s_tready is low while an item is being worked on. An update that finds
// its station refreshes that entry, otherwise it appends a new entry or, on a
// full table, overwrites the entry with the smallest time, the lowest index on
// a tie. A lookup returns the interface of the first matching address. The
// result waits in an output register, so the next item can be taken before
// the previous result is collected. Writing table_size empties the table, and
// a size of zero turns updates into the disabled status.
`default_nettype none

module heard_station_table #(
    parameter int TABLE_DEPTH = hst_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_PATH    = hst_pkg::MAX_PATH_DEF,
    parameter int TIME_BITS   = hst_pkg::TIME_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // station_addr[55:0], type_char[63:56], port_id[67:64], path_len[71:68],
    // now_time[103:72]
    input  wire logic [hst_pkg::IN_DATA_W-1:0]   s_tdata,
    // op[0]
    input  wire logic                            s_tuser,

    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // slot[4:0], found_port[8:5], heard_count[24:9], zero[31:25]
    output logic      [hst_pkg::OUT_DATA_W-1:0]  m_tdata,
    // status[2:0]
    output logic      [hst_pkg::STATUS_W-1:0]    m_tuser,

    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [hst_pkg::APB_AW-1:0]      paddr,
    input  wire logic [hst_pkg::APB_DW-1:0]      pwdata,
    output logic      [hst_pkg::APB_DW-1:0]      prdata,
    output logic                                 pready
);

    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int SIZE_W = hst_pkg::SIZE_W;

    typedef struct packed {
        logic [hst_pkg::ADDR_W-1:0]  key;
        logic [hst_pkg::TYPE_W-1:0]  typ;
        logic [hst_pkg::COUNT_W-1:0] cnt;
        logic [TIME_BITS-1:0]        tim;
        logic [hst_pkg::PORT_W-1:0]  port;
        logic [hst_pkg::PLEN_W-1:0]  plen;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_DONE
    } state_t;

    state_t                          state_reg, state_next;
    logic [SIZE_W-1:0]               size_reg, size_next;
    logic                            tik_reg, tik_next;
    logic [SIZE_W-1:0]               used_reg, used_next;

    hst_pkg::op_t                    op_reg, op_next;
    logic [hst_pkg::ADDR_W-1:0]      key_reg, key_next;
    logic [hst_pkg::TYPE_W-1:0]      typ_reg, typ_next;
    logic [hst_pkg::PORT_W-1:0]      port_reg, port_next;
    logic [hst_pkg::PLEN_W-1:0]      plen_reg, plen_next;
    logic [TIME_BITS-1:0]            time_reg, time_next;

    logic [SIZE_W-1:0]               rd_idx_reg, rd_idx_next;
    logic [SIZE_W-1:0]               chk_idx_reg, chk_idx_next;
    logic                            chk_vld_reg, chk_vld_next;
    logic [SIZE_W-1:0]               best_idx_reg, best_idx_next;
    logic [TIME_BITS-1:0]            best_time_reg, best_time_next;
    entry_t                          ent_reg, ent_next;
    hst_pkg::status_t                act_reg, act_next;
    logic [SIZE_W-1:0]               act_idx_reg, act_idx_next;

    hst_pkg::status_t                res_status_reg, res_status_next;
    logic [SIZE_W-1:0]               res_idx_reg, res_idx_next;
    logic [hst_pkg::PORT_W-1:0]      res_port_reg, res_port_next;
    logic [hst_pkg::COUNT_W-1:0]     res_count_reg, res_count_next;

    logic                            m_tvalid_reg, m_tvalid_next;
    logic [hst_pkg::OUT_DATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic [hst_pkg::STATUS_W-1:0]    m_tuser_reg, m_tuser_next;

    logic                            in_xfer;
    logic                            cfg_wr;
    logic                            out_free;
    logic                            ram_we;
    logic [IDX_W-1:0]                ram_waddr;
    entry_t                          ram_wdata;
    entry_t                          ram_rdata;
    logic                            addr_hit;
    logic                            full_hit;
    logic                            older;
    logic [SIZE_W-1:0]               final_best;
    logic [hst_pkg::COUNT_W-1:0]     new_count;
    logic [SIZE_W-1:0]               size_wr;
    logic [hst_pkg::PLEN_W-1:0]      in_plen;

    hst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (IDX_W'(rd_idx_reg)),
        .rdata (ram_rdata)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign pready   = 1'b1;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == hst_pkg::REG_TYPE_IN_KEY)
        begin
            prdata[0] = tik_reg;
        end
        else
        begin
            prdata[SIZE_W-1:0] = size_reg;
        end
    end

    assign size_wr = (int'(pwdata[SIZE_W-1:0]) > TABLE_DEPTH) ? SIZE_W'(TABLE_DEPTH)
                                                               : pwdata[SIZE_W-1:0];
    assign in_plen = (int'(s_tdata[71:68]) > MAX_PATH) ? hst_pkg::PLEN_W'(MAX_PATH)
                                                        : s_tdata[71:68];

    assign addr_hit   = ((ram_rdata.key ^ key_reg) & hst_pkg::MATCH_MASK) == '0;
    assign full_hit   = addr_hit && (op_reg == hst_pkg::OP_LOOKUP || !tik_reg ||
                                     ram_rdata.typ == typ_reg);
    assign older      = (chk_idx_reg == '0) || (ram_rdata.tim < best_time_reg);
    assign final_best = older ? chk_idx_reg : best_idx_reg;
    assign new_count  = (ent_reg.cnt == '1) ? ent_reg.cnt : ent_reg.cnt + 1'b1;

    always_comb
    begin
        ram_we    = (state_reg == ST_WRITE);
        ram_waddr = IDX_W'(act_idx_reg);
        ram_wdata = ent_reg;
        if (act_reg == hst_pkg::STAT_REFRESHED)
        begin
            ram_wdata.cnt = new_count;
        end
        else
        begin
            ram_wdata.key = key_reg;
            ram_wdata.typ = tik_reg ? typ_reg : hst_pkg::BLANK_TYPE;
            ram_wdata.cnt = hst_pkg::COUNT_W'(1);
        end
        ram_wdata.tim  = time_reg;
        ram_wdata.port = port_reg;
        ram_wdata.plen = plen_reg;
    end

    always_comb
    begin
        state_next      = state_reg;
        size_next       = size_reg;
        tik_next        = tik_reg;
        used_next       = used_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        typ_next        = typ_reg;
        port_next       = port_reg;
        plen_next       = plen_reg;
        time_next       = time_reg;
        rd_idx_next     = rd_idx_reg;
        chk_idx_next    = chk_idx_reg;
        chk_vld_next    = chk_vld_reg;
        best_idx_next   = best_idx_reg;
        best_time_next  = best_time_reg;
        ent_next        = ent_reg;
        act_next        = act_reg;
        act_idx_next    = act_idx_reg;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        res_port_next   = res_port_reg;
        res_count_next  = res_count_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    op_next      = hst_pkg::op_t'(s_tuser);
                    key_next     = s_tdata[55:0];
                    typ_next     = s_tdata[63:56];
                    port_next    = s_tdata[67:64];
                    plen_next    = in_plen;
                    time_next    = TIME_BITS'(s_tdata[103:72]);
                    rd_idx_next  = '0;
                    chk_vld_next = 1'b0;
                    act_idx_next = used_reg;
                    if (hst_pkg::op_t'(s_tuser) == hst_pkg::OP_UPDATE && size_reg == '0)
                    begin
                        res_status_next = hst_pkg::STAT_DISABLED;
                        res_idx_next    = '0;
                        res_port_next   = '0;
                        res_count_next  = '0;
                        state_next      = ST_DONE;
                    end
                    else if (used_reg == '0)
                    begin
                        if (hst_pkg::op_t'(s_tuser) == hst_pkg::OP_LOOKUP)
                        begin
                            res_status_next = hst_pkg::STAT_MISS;
                            res_idx_next    = '0;
                            res_port_next   = '0;
                            res_count_next  = '0;
                            state_next      = ST_DONE;
                        end
                        else
                        begin
                            act_next   = hst_pkg::STAT_INSERTED;
                            state_next = ST_WRITE;
                        end
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                rd_idx_next  = rd_idx_reg + 1'b1;
                chk_idx_next = rd_idx_reg;
                chk_vld_next = (rd_idx_reg < used_reg);
                if (chk_vld_reg)
                begin
                    if (full_hit)
                    begin
                        ent_next     = ram_rdata;
                        act_idx_next = chk_idx_reg;
                        if (op_reg == hst_pkg::OP_LOOKUP)
                        begin
                            res_status_next = hst_pkg::STAT_HIT;
                            res_idx_next    = chk_idx_reg;
                            res_port_next   = ram_rdata.port;
                            res_count_next  = ram_rdata.cnt;
                            state_next      = ST_DONE;
                        end
                        else
                        begin
                            act_next   = hst_pkg::STAT_REFRESHED;
                            state_next = ST_WRITE;
                        end
                    end
                    else
                    begin
                        if (older)
                        begin
                            best_idx_next  = chk_idx_reg;
                            best_time_next = ram_rdata.tim;
                        end
                        if (chk_idx_reg == used_reg - 1'b1)
                        begin
                            if (op_reg == hst_pkg::OP_LOOKUP)
                            begin
                                res_status_next = hst_pkg::STAT_MISS;
                                res_idx_next    = '0;
                                res_port_next   = '0;
                                res_count_next  = '0;
                                state_next      = ST_DONE;
                            end
                            else if (used_reg < size_reg)
                            begin
                                act_next     = hst_pkg::STAT_INSERTED;
                                act_idx_next = used_reg;
                                state_next   = ST_WRITE;
                            end
                            else
                            begin
                                act_next     = hst_pkg::STAT_REPLACED;
                                act_idx_next = final_best;
                                state_next   = ST_WRITE;
                            end
                        end
                    end
                end
            end

            ST_WRITE:
            begin
                res_status_next = act_reg;
                res_idx_next    = act_idx_reg;
                res_port_next   = port_reg;
                res_count_next  = ram_wdata.cnt;
                if (act_reg == hst_pkg::STAT_INSERTED)
                begin
                    used_next = used_reg + 1'b1;
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {7'b0, res_count_reg, res_port_reg,
                                     hst_pkg::SLOT_W'(res_idx_reg)};
                    m_tuser_next  = res_status_reg;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_wr)
        begin
            unique case (paddr[2])
                hst_pkg::REG_TABLE_SIZE:
                begin
                    size_next = size_wr;
                    used_next = '0;
                end
                hst_pkg::REG_TYPE_IN_KEY:
                begin
                    tik_next = pwdata[0];
                end
                default:
                begin
                    tik_next = tik_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            size_reg       <= '0;
            tik_reg        <= 1'b0;
            used_reg       <= '0;
            op_reg         <= hst_pkg::OP_UPDATE;
            key_reg        <= '0;
            typ_reg        <= '0;
            port_reg       <= '0;
            plen_reg       <= '0;
            time_reg       <= '0;
            rd_idx_reg     <= '0;
            chk_idx_reg    <= '0;
            chk_vld_reg    <= 1'b0;
            best_idx_reg   <= '0;
            best_time_reg  <= '0;
            ent_reg        <= '0;
            act_reg        <= hst_pkg::STAT_INSERTED;
            act_idx_reg    <= '0;
            res_status_reg <= hst_pkg::STAT_MISS;
            res_idx_reg    <= '0;
            res_port_reg   <= '0;
            res_count_reg  <= '0;
            m_tvalid_reg   <= 1'b0;
            m_tdata_reg    <= '0;
            m_tuser_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            size_reg       <= size_next;
            tik_reg        <= tik_next;
            used_reg       <= used_next;
            op_reg         <= op_next;
            key_reg        <= key_next;
            typ_reg        <= typ_next;
            port_reg       <= port_next;
            plen_reg       <= plen_next;
            time_reg       <= time_next;
            rd_idx_reg     <= rd_idx_next;
            chk_idx_reg    <= chk_idx_next;
            chk_vld_reg    <= chk_vld_next;
            best_idx_reg   <= best_idx_next;
            best_time_reg  <= best_time_next;
            ent_reg        <= ent_next;
            act_reg        <= act_next;
            act_idx_reg    <= act_idx_next;
            res_status_reg <= res_status_next;
            res_idx_reg    <= res_idx_next;
            res_port_reg   <= res_port_next;
            res_count_reg  <= res_count_next;
            m_tvalid_reg   <= m_tvalid_next;
            m_tdata_reg    <= m_tdata_next;
            m_tuser_reg    <= m_tuser_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/hst_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module hst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ tb/sv/heard_station_table_test.sv @@
// Testbench of the heard station table: directed and random transfers checked against a predictor.
`timescale 1ns / 100ps

module heard_station_table_test;
    import hst_pkg::*;

    localparam int DEPTH       = TABLE_DEPTH_DEF;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT  = 5000;
    localparam int POOL_MAX    = 40;

    typedef struct {
        op_t               op;
        logic [ADDR_W-1:0] station_addr;
        logic [TYPE_W-1:0] type_char;
        logic [PORT_W-1:0] port_id;
        logic [PLEN_W-1:0] path_len;
        logic [NOW_W-1:0]  now_time;
    } station_item_t;

    typedef struct {
        status_t            status;
        logic [SLOT_W-1:0]  slot;
        logic [PORT_W-1:0]  found_port;
        logic [COUNT_W-1:0] heard_count;
    } heard_result_t;

    typedef enum int
    {
        SINK_ALWAYS,
        SINK_RANDOM,
        SINK_PATTERN
    } sink_mode_t;

    class heard_table_scoreboard;
        logic [ADDR_W-1:0]  keys      [DEPTH];
        logic [TYPE_W-1:0]  kinds     [DEPTH];
        logic [COUNT_W-1:0] counts    [DEPTH];
        logic [NOW_W-1:0]   heard_at  [DEPTH];
        logic [PORT_W-1:0]  ports     [DEPTH];
        logic [PLEN_W-1:0]  path_lens [DEPTH];
        int                 size_limit;
        int                 in_use;
        bit                 type_keyed;
        heard_result_t      expected_q [$];
        int                 mismatches;

        function new();
            size_limit = 0;
            in_use     = 0;
            type_keyed = 0;
            mismatches = 0;
        endfunction

        function void set_size(logic [SIZE_W-1:0] value);
            size_limit = (value > DEPTH) ? DEPTH : int'(value);
            in_use     = 0;
        endfunction

        function void set_type_key(logic value);
            type_keyed = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function bit same_station(logic [ADDR_W-1:0] a, logic [ADDR_W-1:0] b);
            return ((a ^ b) & MATCH_MASK) == '0;
        endfunction

        function void fill(int idx, station_item_t it, logic [PLEN_W-1:0] plen);
            keys[idx]      = it.station_addr;
            kinds[idx]     = type_keyed ? it.type_char : BLANK_TYPE;
            counts[idx]    = 1;
            heard_at[idx]  = it.now_time;
            ports[idx]     = it.port_id;
            path_lens[idx] = plen;
        endfunction

        function void note_input(station_item_t it);
            heard_result_t     res;
            status_t           st;
            logic [PLEN_W-1:0] plen;
            int                hit;
            plen = (it.path_len > MAX_PATH_DEF) ? PLEN_W'(MAX_PATH_DEF) : it.path_len;
            hit  = -1;
            if (it.op == OP_LOOKUP)
            begin
                for (int i = 0; i < in_use && hit < 0; i++)
                begin
                    if (same_station(keys[i], it.station_addr))
                        hit = i;
                end
                st = (hit >= 0) ? STAT_HIT : STAT_MISS;
            end
            else if (size_limit == 0)
            begin
                st = STAT_DISABLED;
            end
            else
            begin
                for (int i = 0; i < in_use && hit < 0; i++)
                begin
                    if (same_station(keys[i], it.station_addr) &&
                        (!type_keyed || kinds[i] == it.type_char))
                        hit = i;
                end
                if (hit >= 0)
                begin
                    if (counts[hit] != {COUNT_W{1'b1}})
                        counts[hit]++;
                    heard_at[hit]  = it.now_time;
                    ports[hit]     = it.port_id;
                    path_lens[hit] = plen;
                    st = STAT_REFRESHED;
                end
                else if (in_use < size_limit)
                begin
                    hit = in_use;
                    fill(hit, it, plen);
                    in_use++;
                    st = STAT_INSERTED;
                end
                else
                begin
                    hit = 0;
                    for (int i = 1; i < in_use; i++)
                    begin
                        if (heard_at[i] < heard_at[hit])
                            hit = i;
                    end
                    fill(hit, it, plen);
                    st = STAT_REPLACED;
                end
            end
            res.status = st;
            if (hit >= 0)
            begin
                res.slot        = SLOT_W'(hit);
                res.found_port  = ports[hit];
                res.heard_count = counts[hit];
            end
            else
            begin
                res.slot        = '0;
                res.found_port  = '0;
                res.heard_count = '0;
            end
            expected_q.push_back(res);
        endfunction

        function void check_result(heard_result_t got);
            heard_result_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d slot %0d port %0d count %0d",
                             got.status, got.slot, got.found_port, got.heard_count);
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status || got.slot !== want.slot ||
                got.found_port !== want.found_port || got.heard_count !== want.heard_count)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch at %0t: expected status %0d slot %0d port %0d ",
                              "count %0d, got status %0d slot %0d port %0d count %0d"},
                             $realtime, want.status, want.slot, want.found_port,
                             want.heard_count,
                             got.status, got.slot, got.found_port, got.heard_count);
            end
        endfunction
    endclass

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    wire                   s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  s_tuser  = 1'b0;
    wire                   m_tvalid;
    logic                  m_tready = 1'b0;
    wire  [OUT_DATA_W-1:0] m_tdata;
    wire  [STATUS_W-1:0]   m_tuser;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_AW-1:0]     paddr    = '0;
    logic [APB_DW-1:0]     pwdata   = '0;
    wire  [APB_DW-1:0]     prdata;
    wire                   pready;

    heard_table_scoreboard sb;

    int                gap_max     = 0;
    int                burst_left  = 0;
    sink_mode_t        sink_mode   = SINK_ALWAYS;
    int                ready_pct   = 100;
    logic [7:0]        stall_mask  = 8'hFF;
    int                stall_phase = 0;
    int                hold_asked  = 0;
    int                hold_done   = 0;
    int                hold_left   = 0;
    int                idle_cycles = 0;
    logic [ADDR_W-1:0] station_pool [POOL_MAX];
    int                pool_n      = 4;
    logic [TYPE_W-1:0] kind_pool [3];
    logic [NOW_W-1:0]  now_stamp   = '0;
    int                phase_sizes [14] = '{3, 3, 1, 32, 8, 2, 63, 63, 5, 16, 0, 33, 4, 31};

    heard_station_table u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (hold_left == 0 && hold_asked != hold_done)
        begin
            hold_done = hold_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            case (sink_mode)
                SINK_ALWAYS:
                    m_tready <= 1'b1;
                SINK_RANDOM:
                    m_tready <= ($urandom_range(0, 99) < ready_pct);
                default:
                    m_tready <= stall_mask[stall_phase % 8];
            endcase
        end
        stall_phase++;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(heard_result_t'{status_t'(m_tuser),
                                            m_tdata[SLOT_W-1:0],
                                            m_tdata[SLOT_W+PORT_W-1:SLOT_W],
                                            m_tdata[SLOT_W+PORT_W+COUNT_W-1:SLOT_W+PORT_W]});
    end

    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAIL");
        $finish;
    end

    function automatic station_item_t mk(op_t op, logic [ADDR_W-1:0] addr,
                                         logic [TYPE_W-1:0] kind, logic [PORT_W-1:0] port,
                                         logic [PLEN_W-1:0] plen, logic [NOW_W-1:0] stamp);
        station_item_t it;
        it.op           = op;
        it.station_addr = addr;
        it.type_char    = kind;
        it.port_id      = port;
        it.path_len     = plen;
        it.now_time     = stamp;
        return it;
    endfunction

    // Mostly stations from the phase pool with the don't-care address bits scrambled,
    // so refreshes, hits and replacements dominate; the rest is random noise.
    function automatic station_item_t random_station();
        station_item_t     it;
        logic [ADDR_W-1:0] noise;
        int                pick;
        noise = ADDR_W'({$urandom, $urandom});
        it.op = ($urandom_range(0, 99) < 25) ? OP_LOOKUP : OP_UPDATE;
        if ($urandom_range(0, 99) < 85)
            it.station_addr = (station_pool[$urandom_range(0, pool_n - 1)] & MATCH_MASK) |
                              (noise & ~MATCH_MASK);
        else
            it.station_addr = noise;
        it.type_char = ($urandom_range(0, 99) < 80) ? kind_pool[$urandom_range(0, 2)]
                                                    : TYPE_W'($urandom);
        it.port_id  = PORT_W'($urandom);
        it.path_len = PLEN_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 15)
            now_stamp = $urandom;
        else if (pick < 85)
            now_stamp += NOW_W'($urandom_range(1, 3));
        it.now_time = now_stamp;
        return it;
    endfunction

    task automatic send_item(station_item_t it);
        s_tvalid <= 1'b1;
        s_tdata  <= {it.now_time, it.path_len, it.port_id, it.type_char, it.station_addr};
        s_tuser  <= it.op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_input(it);
    endtask

    task automatic pace();
        if (gap_max == 0)
            return;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, gap_max))
                @(posedge clk);
            burst_left = $urandom_range(0, 15);
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
    endtask

    task automatic write_reg(logic sel, logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (sel == REG_TABLE_SIZE)
            sb.set_size(value[SIZE_W-1:0]);
        else
            sb.set_type_key(value[0]);
    endtask

    task automatic random_phase(int size, bit key, bit keep_table, int n,
                                bit hold_off, bit pause_mid);
        settle();
        if (!keep_table)
            write_reg(REG_TABLE_SIZE, ($urandom & ~32'h3F) | APB_DW'(size));
        write_reg(REG_TYPE_IN_KEY, ($urandom & ~32'h1) | APB_DW'(key));
        pool_n = ((size > DEPTH) ? DEPTH : size) + 4;
        for (int i = 0; i < pool_n; i++)
            station_pool[i] = ADDR_W'({$urandom, $urandom});
        for (int i = 0; i < 3; i++)
            kind_pool[i] = TYPE_W'($urandom);
        gap_max    = ($urandom_range(0, 3) == 0 || hold_off) ? 0 : $urandom_range(1, 12);
        burst_left = 0;
        sink_mode  = sink_mode_t'($urandom_range(0, 2));
        ready_pct  = $urandom_range(30, 90);
        stall_mask = 8'($urandom) | 8'h01;
        for (int k = 0; k < n; k++)
        begin
            if (hold_off && k == n / 3)
                hold_asked++;
            if (pause_mid && k == n / 2)
            begin
                s_tvalid <= 1'b0;
                do
                    @(posedge clk);
                while (sb.pending() != 0);
            end
            send_item(random_station());
            pace();
        end
    endtask

    initial
    begin
        sb = new();
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Disabled table right after reset.
        send_item(mk(OP_UPDATE, '1, 8'hFF, 4'hF, 4'hF, '1));
        send_item(mk(OP_LOOKUP, '1, 8'hFF, 4'hF, 4'hF, '1));
        settle();
        write_reg(REG_TYPE_IN_KEY, 32'h1);
        write_reg(REG_TABLE_SIZE, 32'h2);
        send_item(mk(OP_LOOKUP, '0, 8'h00, 4'h0, 4'h0, '0));
        send_item(mk(OP_UPDATE, '1, 8'hFF, 4'hF, 4'hF, 32'hFFFF_FFFF));
        send_item(mk(OP_UPDATE, '0, 8'h00, 4'h0, 4'h0, 32'h0000_0000));
        send_item(mk(OP_UPDATE, ~ADDR_W'(8'hE1), 8'hFF, 4'h3, 4'h9, 32'h8000_0000));
        send_item(mk(OP_LOOKUP, ~ADDR_W'(8'h02), 8'hFF, 4'h0, 4'h0, 32'h0));
        send_item(mk(OP_LOOKUP, ~(ADDR_W'(1) << 55), 8'hFF, 4'h0, 4'h0, 32'h0));
        send_item(mk(OP_LOOKUP, ~ADDR_W'(8'hE1), 8'h00, 4'h0, 4'h0, 32'h0));
        // Same address with another type on a full table, then an unsigned age compare.
        send_item(mk(OP_UPDATE, '1, 8'h41, 4'h5, 4'h2, 32'h7FFF_FFFF));
        send_item(mk(OP_UPDATE, 56'h12_3456_789A_BCDE, 8'h20, 4'h6, 4'h1, 32'h10));
        send_item(mk(OP_LOOKUP, 56'h12_3456_789A_BCDE, 8'h00, 4'h0, 4'h0, 32'h0));
        settle();
        write_reg(REG_TYPE_IN_KEY, 32'hFFFF_FFFE);
        send_item(mk(OP_UPDATE, '1, 8'h55, 4'h7, 4'h3, 32'h50));
        send_item(mk(OP_UPDATE, 56'h12_3456_789A_BCDE, 8'h20, 4'h8, 4'h4, 32'h50));
        // Equal ages: the lowest index is replaced.
        send_item(mk(OP_UPDATE, 56'hA5_A5A5_A5A5_A5A5, 8'h3A, 4'h9, 4'h0, 32'h60));
        settle();
        write_reg(REG_TABLE_SIZE, 32'hFFFF_FFFF);
        send_item(mk(OP_LOOKUP, 56'hA5_A5A5_A5A5_A5A5, 8'h3A, 4'h0, 4'h0, 32'h0));
        send_item(mk(OP_UPDATE, 56'hA5_A5A5_A5A5_A5A5, 8'h3A, 4'h1, 4'h8, 32'h70));
        send_item(mk(OP_UPDATE, 56'h5A_5A5A_5A5A_5A5A, 8'h3B, 4'h2, 4'hC, 32'h71));
        send_item(mk(OP_UPDATE, 56'h00_FF00_FF00_FF00, 8'h3C, 4'h4, 4'h7, 32'h72));
        send_item(mk(OP_UPDATE, 56'hA5_A5A5_A5A5_A5A5, 8'h3A, 4'hA, 4'hF, 32'h73));
        settle();
        write_reg(REG_TABLE_SIZE, 32'h1);
        send_item(mk(OP_UPDATE, 56'h5A_5A5A_5A5A_5A5A, 8'h3B, 4'hB, 4'h1, 32'h80));
        send_item(mk(OP_UPDATE, 56'h00_FF00_FF00_FF00, 8'h3C, 4'hC, 4'h2, 32'h81));

        for (int p = 0; p < 14; p++)
            random_phase(phase_sizes[p], p % 2, p > 0 && phase_sizes[p] == phase_sizes[p - 1],
                         136, p == 3 || p == 8, p == 5 || p == 10);

        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (40)
            @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
